// ===== rtl/rgba_2x2_box_downsample_core_defines.svh =====
// Assertion macros shared by the downsampler RTL.
`ifndef RGBA_2X2_BOX_DOWNSAMPLE_CORE_DEFINES_SVH
`define RGBA_2X2_BOX_DOWNSAMPLE_CORE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RBD_ASSERT_SAME(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// The consequent must hold in the cycle after the antecedent.
`define RBD_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

// ===== rtl/rbd_pkg.sv =====
`timescale 1ns / 1ps

package rbd_pkg;

    localparam int CH_W      = 8;   // one colour channel
    localparam int LANE_W    = 9;   // sum of two channels
    localparam int CFG_W     = 13;  // width of both configuration registers
    localparam int CFG_IDX_W = 2;

    localparam int DEF_MAX_LINE_LENGTH = 4096;
    localparam int DEF_MAX_LINE_COUNT  = 4096;

    localparam logic [CFG_W-1:0] LINE_LENGTH_RESET = 13'd256;
    localparam logic [CFG_W-1:0] LINE_COUNT_RESET  = 13'd256;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LINE_LENGTH = 2'd0,
        CFG_LINE_COUNT  = 2'd1
    } cfg_index_t;

endpackage

// ===== rtl/rgba_2x2_box_downsample_core.sv =====
`timescale 1ns / 1ps
// 2x2 box-filter downsampler for RGBA8 pixels in raster order. One pixel is accepted per
// clock while s_ready is high; each accepted pixel makes at most one access to the line
// store (a write on the odd position of an even line, a read on the odd position of an
// odd line, none otherwise), which is what sets the rate of one pixel per cycle. The edge
// that accepts the pixel completing its 2x2 block performs the synchronous line-store read
// into rd_data_reg and loads stage one; the final add then goes into the output register,
// which raises m_valid, as soon as that register is free. The input is held off only while
// a word waits in the output register and another waits in the stage behind it. Writing
// either configuration register restarts the image at line 0, position 0; the line store
// needs no clearing because an odd line only reads entries the even line before it wrote.
// Sizes are clamped to [2, MAX] and a trailing odd pixel or line produces no result.

`include "rgba_2x2_box_downsample_core_defines.svh"

module rgba_2x2_box_downsample_core #(
    parameter int MAX_LINE_LENGTH = rbd_pkg::DEF_MAX_LINE_LENGTH,
    parameter int MAX_LINE_COUNT  = rbd_pkg::DEF_MAX_LINE_COUNT
) (
    input  logic                        aclk,
    input  logic                        aresetn,

    input  logic                        cfg_wr_en,
    input  logic [rbd_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [rbd_pkg::CFG_W-1:0]   cfg_data,

    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [rbd_pkg::CH_W-1:0]    s_red_in,
    input  logic [rbd_pkg::CH_W-1:0]    s_green_in,
    input  logic [rbd_pkg::CH_W-1:0]    s_blue_in,
    input  logic [rbd_pkg::CH_W-1:0]    s_alpha_in,

    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [rbd_pkg::CH_W-1:0]    m_red_out,
    output logic [rbd_pkg::CH_W-1:0]    m_green_out,
    output logic [rbd_pkg::CH_W-1:0]    m_blue_out,
    output logic [rbd_pkg::CH_W-1:0]    m_alpha_out,
    output logic                        m_last_of_image
);

    localparam int CH_W   = rbd_pkg::CH_W;
    localparam int LANE_W = rbd_pkg::LANE_W;
    localparam int WORD_W = 4 * LANE_W;
    localparam int PIX_W  = 4 * CH_W;

    localparam int POS_W  = ($clog2(MAX_LINE_LENGTH) < 2) ? 2 : $clog2(MAX_LINE_LENGTH);
    localparam int LEN_W  = POS_W + 1;
    localparam int ADDR_W = POS_W - 1;
    localparam int DEPTH  = (MAX_LINE_LENGTH / 2 < 1) ? 1 : MAX_LINE_LENGTH / 2;
    localparam int LN_W   = ($clog2(MAX_LINE_COUNT) < 1) ? 1 : $clog2(MAX_LINE_COUNT);
    localparam int CNT_W  = LN_W + 1;

    // Configuration registers, kept as written; clamping is done on the read side.
    logic [rbd_pkg::CFG_W-1:0] line_length_reg;
    logic [rbd_pkg::CFG_W-1:0] line_count_reg;
    logic                      restart;

    always_comb begin
        restart = 1'b0;
        if (cfg_wr_en) begin
            unique case (cfg_index)
                rbd_pkg::CFG_LINE_LENGTH,
                rbd_pkg::CFG_LINE_COUNT: restart = 1'b1;
                default:                 restart = 1'b0;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            line_length_reg <= rbd_pkg::LINE_LENGTH_RESET;
            line_count_reg  <= rbd_pkg::LINE_COUNT_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                rbd_pkg::CFG_LINE_LENGTH: line_length_reg <= cfg_data;
                rbd_pkg::CFG_LINE_COUNT:  line_count_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    logic [LEN_W-1:0] len;
    logic [LEN_W-1:0] len_even;
    logic [CNT_W-1:0] cnt;
    logic [CNT_W-1:0] cnt_even;

    always_comb begin
        if (line_length_reg < rbd_pkg::CFG_W'(2)) begin
            len = LEN_W'(2);
        end else if (32'(line_length_reg) > MAX_LINE_LENGTH) begin
            len = LEN_W'(MAX_LINE_LENGTH);
        end else begin
            len = LEN_W'(line_length_reg);
        end
        if (line_count_reg < rbd_pkg::CFG_W'(2)) begin
            cnt = CNT_W'(2);
        end else if (32'(line_count_reg) > MAX_LINE_COUNT) begin
            cnt = CNT_W'(MAX_LINE_COUNT);
        end else begin
            cnt = CNT_W'(line_count_reg);
        end
        len_even = {len[LEN_W-1:1], 1'b0};
        cnt_even = {cnt[CNT_W-1:1], 1'b0};
    end

    // Position and line counters.
    logic [POS_W-1:0] pos_reg;
    logic [LN_W-1:0]  line_reg;
    logic [LEN_W-1:0] pos_ext;
    logic [CNT_W-1:0] line_ext;
    logic             end_of_line;
    logic             active;
    logic             is_last;

    assign pos_ext     = {1'b0, pos_reg};
    assign line_ext    = {1'b0, line_reg};
    assign end_of_line = (pos_ext == len - LEN_W'(1));
    assign active      = (pos_ext < len_even) && (line_ext < cnt_even);
    assign is_last     = (pos_ext == len_even - LEN_W'(1)) &&
                         (line_ext == cnt_even - CNT_W'(1));

    // Handshake and pipeline control.
    logic s1_valid_reg;
    logic out_valid_reg;
    logic s1_adv;
    logic s_acc;
    logic produce;

    assign s1_adv  = !out_valid_reg || m_ready;
    assign s_ready = !s1_valid_reg || s1_adv;
    assign s_acc   = s_valid && s_ready;
    assign produce = active && pos_reg[0] && line_reg[0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg  <= '0;
            line_reg <= '0;
        end else if (restart) begin
            pos_reg  <= '0;
            line_reg <= '0;
        end else if (s_acc) begin
            if (end_of_line) begin
                pos_reg <= '0;
                if (line_ext == cnt - CNT_W'(1)) begin
                    line_reg <= '0;
                end else begin
                    line_reg <= line_reg + LN_W'(1);
                end
            end else begin
                pos_reg <= pos_reg + POS_W'(1);
            end
        end
    end

    // Channels of the even-position pixel, waiting for its partner.
    logic [PIX_W-1:0] pair_hold_reg;
    logic [PIX_W-1:0] pixel;
    logic [WORD_W-1:0] pair_sum;

    assign pixel = {s_alpha_in, s_blue_in, s_green_in, s_red_in};

    always_comb begin
        for (int k = 0; k < 4; k++) begin
            pair_sum[k*LANE_W +: LANE_W] = LANE_W'(pair_hold_reg[k*CH_W +: CH_W]) +
                                           LANE_W'(pixel[k*CH_W +: CH_W]);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pair_hold_reg <= '0;
        end else if (s_acc && active && !pos_reg[0]) begin
            pair_hold_reg <= pixel;
        end
    end

    // Line store: at most one write or one read per accepted pixel, never both.
    logic [WORD_W-1:0] pair_sum_store [DEPTH];
    logic [WORD_W-1:0] rd_data_reg;
    logic [ADDR_W-1:0] slot;
    logic              mem_wr_en;
    logic              mem_rd_en;

    assign slot      = pos_reg[POS_W-1:1];
    assign mem_wr_en = s_acc && active && pos_reg[0] && !line_reg[0];
    assign mem_rd_en = s_acc && produce;

    always_ff @(posedge aclk) begin
        if (mem_wr_en) begin
            pair_sum_store[slot] <= pair_sum;
        end
        if (mem_rd_en) begin
            rd_data_reg <= pair_sum_store[slot];
        end
    end

    // Stage one: bottom-pair sum waits for the top-pair sum from the store.
    logic [WORD_W-1:0] s1_sum_reg;
    logic              s1_last_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (mem_rd_en) begin
            s1_valid_reg <= 1'b1;
        end else if (s1_adv) begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_rd_en) begin
            s1_sum_reg  <= pair_sum;
            s1_last_reg <= is_last;
        end
    end

    // Output register: the four-value total divided by four.
    logic [PIX_W-1:0] avg;
    logic [PIX_W-1:0] out_pix_reg;
    logic             out_last_reg;

    always_comb begin
        logic [LANE_W:0] total;
        total = '0;
        for (int k = 0; k < 4; k++) begin
            total = (LANE_W + 1)'(rd_data_reg[k*LANE_W +: LANE_W]) +
                    (LANE_W + 1)'(s1_sum_reg[k*LANE_W +: LANE_W]);
            avg[k*CH_W +: CH_W] = total[LANE_W:2];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (s1_adv) begin
            out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_adv && s1_valid_reg) begin
            out_pix_reg  <= avg;
            out_last_reg <= s1_last_reg;
        end
    end

    assign m_valid         = out_valid_reg;
    assign m_red_out       = out_pix_reg[0*CH_W +: CH_W];
    assign m_green_out     = out_pix_reg[1*CH_W +: CH_W];
    assign m_blue_out      = out_pix_reg[2*CH_W +: CH_W];
    assign m_alpha_out     = out_pix_reg[3*CH_W +: CH_W];
    assign m_last_of_image = out_last_reg;

    `RBD_ASSERT_SAME(a_no_rd_wr_clash, aclk, aresetn, mem_wr_en, !mem_rd_en)
    `RBD_ASSERT_NEXT(a_rd_data_held, aclk, aresetn, s1_valid_reg && !s1_adv,
                     s1_valid_reg && $stable(rd_data_reg) && $stable(s1_sum_reg))
    `RBD_ASSERT_SAME(a_full_blocks_input, aclk, aresetn, s1_valid_reg && !s1_adv, !s_ready)
    `RBD_ASSERT_NEXT(a_read_fills_stage, aclk, aresetn, mem_rd_en, s1_valid_reg)

endmodule

// ===== tb/rgba_2x2_box_downsample_core_checker.sv =====
`timescale 1ns / 1ps

module rgba_2x2_box_downsample_core_checker (
    input  logic                          aclk,
    input  logic                          aresetn,

    input  logic                          cfg_wr_en,
    input  logic [rbd_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [rbd_pkg::CFG_W-1:0]     cfg_data,

    input  logic                          s_valid,
    input  logic                          s_ready,
    input  logic [rbd_pkg::CH_W-1:0]      s_red_in,
    input  logic [rbd_pkg::CH_W-1:0]      s_green_in,
    input  logic [rbd_pkg::CH_W-1:0]      s_blue_in,
    input  logic [rbd_pkg::CH_W-1:0]      s_alpha_in,

    input  logic                          m_valid,
    input  logic                          m_ready,
    input  logic [rbd_pkg::CH_W-1:0]      m_red_out,
    input  logic [rbd_pkg::CH_W-1:0]      m_green_out,
    input  logic [rbd_pkg::CH_W-1:0]      m_blue_out,
    input  logic [rbd_pkg::CH_W-1:0]      m_alpha_out,
    input  logic                          m_last_of_image,

    output int                            outstanding,
    output int                            fail_count
);

    localparam int CH_W        = rbd_pkg::CH_W;
    localparam int LANE_W      = rbd_pkg::LANE_W;
    localparam int CFG_W       = rbd_pkg::CFG_W;
    localparam int STORE_DEPTH = rbd_pkg::DEF_MAX_LINE_LENGTH / 2;
    localparam int PAIR_W      = 4 * LANE_W;

    typedef struct packed {
        logic [CH_W-1:0] red;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] blue;
        logic [CH_W-1:0] alpha;
        logic            last;
    } block_avg_t;

    block_avg_t        pending_avgs[$];
    logic [PAIR_W-1:0] pair_sums[STORE_DEPTH];
    logic [PAIR_W-1:0] held_pair;
    logic [CFG_W-1:0]  len_reg;
    logic [CFG_W-1:0]  cnt_reg;
    int unsigned       col_pos;
    int unsigned       row_pos;
    int                err_total;

    function automatic int unsigned clamp_size(input logic [CFG_W-1:0] v, input int unsigned hi);
        if (v < 2)
            return 2;
        if (v > hi)
            return hi;
        return 32'(v);
    endfunction

    // Folds one accepted pixel into the line state and queues the block
    // average when the pixel completes a 2x2 block.
    task automatic fold_pixel(input logic [CH_W-1:0] r, input logic [CH_W-1:0] g,
                              input logic [CH_W-1:0] b, input logic [CH_W-1:0] a);
        int unsigned     len;
        int unsigned     cnt;
        int unsigned     len_even;
        int unsigned     cnt_even;
        int unsigned     pos;
        int unsigned     row;
        int unsigned     slot;
        logic [CH_W-1:0] px[4];
        logic [CH_W-1:0] avg[4];
        logic [10:0]     total;
        block_avg_t      word;
        len      = clamp_size(len_reg, rbd_pkg::DEF_MAX_LINE_LENGTH);
        cnt      = clamp_size(cnt_reg, rbd_pkg::DEF_MAX_LINE_COUNT);
        len_even = len & ~32'd1;
        cnt_even = cnt & ~32'd1;
        pos      = col_pos;
        row      = row_pos;
        px[0] = r; px[1] = g; px[2] = b; px[3] = a;
        if (pos >= len)
            pos = 0;
        if (row >= cnt)
            row = 0;
        if (pos < len_even && row < cnt_even) begin
            slot = (pos >> 1) % STORE_DEPTH;
            if ((pos & 1) == 0) begin
                held_pair = {1'b0, a, 1'b0, b, 1'b0, g, 1'b0, r};
            end else if ((row & 1) == 0) begin
                pair_sums[slot] = {held_pair[35:27] + a, held_pair[26:18] + b,
                                   held_pair[17:9] + g, held_pair[8:0] + r};
            end else begin
                for (int k = 0; k < 4; k++) begin
                    total  = 11'(pair_sums[slot][LANE_W*k +: LANE_W])
                           + 11'(held_pair[LANE_W*k +: LANE_W]) + 11'(px[k]);
                    avg[k] = total[9:2];
                end
                word.red   = avg[0];
                word.green = avg[1];
                word.blue  = avg[2];
                word.alpha = avg[3];
                word.last  = (pos == len_even - 1) && (row == cnt_even - 1);
                pending_avgs = {pending_avgs, word};
            end
        end
        pos++;
        if (pos >= len) begin
            pos = 0;
            row++;
            if (row >= cnt)
                row = 0;
        end
        col_pos = pos;
        row_pos = row;
    endtask

    task automatic compare_result();
        block_avg_t want;
        if (pending_avgs.size() == 0) begin
            $error("output word with no 2x2 block pending");
            err_total++;
        end else begin
            want = pending_avgs.pop_front();
            if (m_red_out !== want.red) begin
                $error("red_out: expected %0d, actual %0d", want.red, m_red_out);
                err_total++;
            end
            if (m_green_out !== want.green) begin
                $error("green_out: expected %0d, actual %0d", want.green, m_green_out);
                err_total++;
            end
            if (m_blue_out !== want.blue) begin
                $error("blue_out: expected %0d, actual %0d", want.blue, m_blue_out);
                err_total++;
            end
            if (m_alpha_out !== want.alpha) begin
                $error("alpha_out: expected %0d, actual %0d", want.alpha, m_alpha_out);
                err_total++;
            end
            if (m_last_of_image !== want.last) begin
                $error("last_of_image: expected %0d, actual %0d", want.last,
                       m_last_of_image);
                err_total++;
            end
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            pending_avgs.delete();
            held_pair = '0;
            col_pos   = 0;
            row_pos   = 0;
            len_reg   = rbd_pkg::LINE_LENGTH_RESET;
            cnt_reg   = rbd_pkg::LINE_COUNT_RESET;
        end else begin
            if (m_valid && m_ready)
                compare_result();
            if (cfg_wr_en) begin
                // Only the two known indexes restart the image; the store is kept.
                case (rbd_pkg::cfg_index_t'(cfg_index))
                    rbd_pkg::CFG_LINE_LENGTH: begin
                        len_reg = cfg_data;
                        col_pos = 0;
                        row_pos = 0;
                    end
                    rbd_pkg::CFG_LINE_COUNT: begin
                        cnt_reg = cfg_data;
                        col_pos = 0;
                        row_pos = 0;
                    end
                    default: ;
                endcase
            end
            if (s_valid && s_ready)
                fold_pixel(s_red_in, s_green_in, s_blue_in, s_alpha_in);
        end
        outstanding <= pending_avgs.size();
        fail_count  <= err_total;
    end

endmodule

// ===== tb/rgba_2x2_box_downsample_core_test.sv =====
`timescale 1ns / 1ps

module rgba_2x2_box_downsample_core_test;

    localparam int CH_W      = rbd_pkg::CH_W;
    localparam int CFG_W     = rbd_pkg::CFG_W;
    localparam int CFG_IDX_W = rbd_pkg::CFG_IDX_W;

    localparam int CLK_HALF    = 2;
    localparam int CYCLE_LIMIT = 100_000;
    localparam int SETTLE      = 8;
    localparam int HOLD_AT     = 200;
    localparam int HOLD_LEN    = 400;
    localparam int CALM_LO     = 1100;
    localparam int CALM_HI     = 1400;
    localparam int TOTAL_ITEMS = 1550;
    localparam int WIDE_PIXELS = 128;
    localparam int TALL_PIXELS = 256;

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;
    localparam logic [CFG_W-1:0]     CFG_ALL_ONES = '1;

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0]     cfg_data  = '0;
    logic                 s_valid   = 1'b0;
    logic                 s_ready;
    logic [CH_W-1:0]      s_red_in   = '0;
    logic [CH_W-1:0]      s_green_in = '0;
    logic [CH_W-1:0]      s_blue_in  = '0;
    logic [CH_W-1:0]      s_alpha_in = '0;
    logic                 m_valid;
    logic                 m_ready   = 1'b0;
    logic [CH_W-1:0]      m_red_out;
    logic [CH_W-1:0]      m_green_out;
    logic [CH_W-1:0]      m_blue_out;
    logic [CH_W-1:0]      m_alpha_out;
    logic                 m_last_of_image;

    int                   outstanding;
    int                   fail_count;
    int unsigned          pixels_sent = 0;
    int unsigned          cycle_count = 0;
    int unsigned          hold_left   = 0;
    bit                   hold_done   = 1'b0;
    logic [CFG_W-1:0]     len_raw     = rbd_pkg::LINE_LENGTH_RESET;
    logic [CFG_W-1:0]     cnt_raw     = rbd_pkg::LINE_COUNT_RESET;

    always #(CLK_HALF) aclk = ~aclk;

    rgba_2x2_box_downsample_core u_top (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_red_in        (s_red_in),
        .s_green_in      (s_green_in),
        .s_blue_in       (s_blue_in),
        .s_alpha_in      (s_alpha_in),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_red_out       (m_red_out),
        .m_green_out     (m_green_out),
        .m_blue_out      (m_blue_out),
        .m_alpha_out     (m_alpha_out),
        .m_last_of_image (m_last_of_image)
    );

    rgba_2x2_box_downsample_core_checker u_check (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_red_in        (s_red_in),
        .s_green_in      (s_green_in),
        .s_blue_in       (s_blue_in),
        .s_alpha_in      (s_alpha_in),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_red_out       (m_red_out),
        .m_green_out     (m_green_out),
        .m_blue_out      (m_blue_out),
        .m_alpha_out     (m_alpha_out),
        .m_last_of_image (m_last_of_image),
        .outstanding     (outstanding),
        .fail_count      (fail_count)
    );

    function automatic bit calm_window();
        return pixels_sent >= CALM_LO && pixels_sent < CALM_HI;
    endfunction

    function automatic int unsigned eff_size(input logic [CFG_W-1:0] v, input int unsigned hi);
        if (v < 2)
            return 2;
        if (v > hi)
            return hi;
        return 32'(v);
    endfunction

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // The receiver holds off once for a long stretch so that the block backs up.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_left != 0) begin
            m_ready   <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (!hold_done && pixels_sent >= HOLD_AT) begin
            hold_done <= 1'b1;
            hold_left <= HOLD_LEN;
            m_ready   <= 1'b0;
        end else if (calm_window()) begin
            m_ready <= 1'b1;
        end else begin
            m_ready <= ($urandom_range(0, 99) >= 25);
        end
    end

    // Random gaps before about one pixel in eight, outside the calm window, keep the sender
    // idle for roughly a quarter of the time.
    task automatic send_pixel(input logic [CH_W-1:0] r, input logic [CH_W-1:0] g,
                              input logic [CH_W-1:0] b, input logic [CH_W-1:0] a);
        if (!calm_window() && $urandom_range(0, 99) < 13) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge aclk);
        end
        s_valid    <= 1'b1;
        s_red_in   <= r;
        s_green_in <= g;
        s_blue_in  <= b;
        s_alpha_in <= a;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        pixels_sent++;
    endtask

    task automatic send_random_pixel();
        logic [CH_W-1:0] c[4];
        bit              extreme;
        extreme = ($urandom_range(0, 99) < 10);
        for (int k = 0; k < 4; k++)
            c[k] = extreme ? ($urandom_range(0, 1) ? 8'hFF : 8'h00) : 8'($urandom_range(0, 255));
        send_pixel(c[0], c[1], c[2], c[3]);
    endtask

    task automatic send_grey(input logic [CH_W-1:0] v, input int unsigned n);
        repeat (n) send_pixel(v, v, v, v);
    endtask

    // The outstanding count is registered in the checker, so the task lets it update before reading it.
    task automatic wait_drained();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (outstanding != 0)
            @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        wait_drained();
        // A trailing pixel that makes no word may still be in flight.
        repeat (SETTLE) @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
        if (idx == rbd_pkg::CFG_LINE_LENGTH)
            len_raw = data;
        else if (idx == rbd_pkg::CFG_LINE_COUNT)
            cnt_raw = data;
    endtask

    initial begin
        int unsigned n;
        int unsigned len;
        int unsigned cnt;
        bit          wrote;
        bit          pause_mid;

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Two lines at the reset sizes.
        for (int i = 0; i < 2 * rbd_pkg::LINE_LENGTH_RESET; i++)
            send_random_pixel();

        // Sizes below the minimum are raised to 2x2; saturated and empty blocks.
        write_reg(rbd_pkg::CFG_LINE_LENGTH, 13'd0);
        write_reg(rbd_pkg::CFG_LINE_COUNT, 13'd1);
        send_grey(8'hFF, 4);
        send_grey(8'h00, 4);

        // Odd sizes: the third pixel of each line and the third line make no word.
        write_reg(rbd_pkg::CFG_LINE_LENGTH, 13'd3);
        write_reg(rbd_pkg::CFG_LINE_COUNT, 13'd3);
        send_pixel(8'hFF, 8'h00, 8'h55, 8'hAA);
        send_pixel(8'hFF, 8'h01, 8'hAA, 8'h55);
        send_pixel(8'h00, 8'hFF, 8'h00, 8'hFF);
        send_pixel(8'hFE, 8'h02, 8'h55, 8'hAA);
        send_pixel(8'hFF, 8'h00, 8'hAA, 8'h55);
        send_pixel(8'hFF, 8'hFF, 8'hFF, 8'hFF);
        send_grey(8'h80, 3);

        // Writes to unknown indexes mid-image must not restart it.
        write_reg(rbd_pkg::CFG_LINE_LENGTH, 13'd4);
        write_reg(rbd_pkg::CFG_LINE_COUNT, 13'd2);
        send_pixel(8'h10, 8'h20, 8'h30, 8'h40);
        send_pixel(8'hF0, 8'hE0, 8'hD0, 8'hC0);
        send_pixel(8'h01, 8'h02, 8'h03, 8'h04);
        send_pixel(8'h7F, 8'h80, 8'h81, 8'h82);
        write_reg(CFG_SPARE_A, CFG_ALL_ONES);
        write_reg(CFG_SPARE_B, 13'd5);
        send_pixel(8'h33, 8'hCC, 8'h0F, 8'hF0);
        send_pixel(8'h03, 8'h03, 8'h03, 8'h03);
        send_pixel(8'hFF, 8'hFF, 8'h00, 8'h00);
        send_pixel(8'h00, 8'h01, 8'hFE, 8'hFF);

        // Largest line with the fewest lines, then the reverse; only the start of
        // each image is sent.
        write_reg(rbd_pkg::CFG_LINE_LENGTH, CFG_ALL_ONES);
        write_reg(rbd_pkg::CFG_LINE_COUNT, 13'd2);
        repeat (WIDE_PIXELS) send_random_pixel();
        write_reg(rbd_pkg::CFG_LINE_LENGTH, 13'd2);
        write_reg(rbd_pkg::CFG_LINE_COUNT, CFG_ALL_ONES);
        repeat (TALL_PIXELS) send_random_pixel();

        while (pixels_sent < TOTAL_ITEMS) begin
            wrote = 1'b0;
            if ($urandom_range(0, 99) < 70) begin
                write_reg(rbd_pkg::CFG_LINE_LENGTH, ($urandom_range(0, 99) < 10) ?
                          13'($urandom_range(0, 1)) : 13'($urandom_range(2, 32)));
                wrote = 1'b1;
            end
            if (!wrote || $urandom_range(0, 99) < 70)
                write_reg(rbd_pkg::CFG_LINE_COUNT, ($urandom_range(0, 99) < 10) ?
                          13'($urandom_range(0, 1)) : 13'($urandom_range(2, 10)));
            if ($urandom_range(0, 99) < 10)
                write_reg($urandom_range(0, 1) ? CFG_SPARE_A : CFG_SPARE_B,
                          13'($urandom_range(0, 8191)));
            len = eff_size(len_raw, rbd_pkg::DEF_MAX_LINE_LENGTH);
            cnt = eff_size(cnt_raw, rbd_pkg::DEF_MAX_LINE_COUNT);
            // Mostly whole images; the rest break off mid-image.
            if ($urandom_range(0, 99) < 80)
                n = len * cnt * $urandom_range(1, 3);
            else
                n = $urandom_range(1, 2 * len * cnt);
            if (n > TOTAL_ITEMS - pixels_sent)
                n = TOTAL_ITEMS - pixels_sent;
            pause_mid = ($urandom_range(0, 99) < 15);
            for (int unsigned i = 0; i < n; i++) begin
                if (pause_mid && i == n / 2)
                    wait_drained();
                send_random_pixel();
            end
        end

        wait_drained();
        repeat (SETTLE) @(posedge aclk);
        if (fail_count == 0 && outstanding == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
